FILE: hw/rtl/rti_pkg.sv
// shared widths, register indexes and word types of the ray/triangle tester
package rti_pkg;

  localparam int CW   = 21;
  localparam int VW   = 3 * CW;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * CW + 2;
  localparam int QW   = 2 * CW + 3;
  localparam int SPL  = EW;
  localparam int HW   = QW - SPL;
  localparam int MW   = EW + HW;
  localparam int DW   = 68;
  localparam int QTW  = 32;
  localparam int FXW  = 16;
  localparam int NW   = DW + FXW;
  localparam int RW   = DW + QTW;
  localparam int MATW = 16;
  localparam int EPSW = 16;
  localparam int IDXW = 3;
  localparam int ITDW = ((2 * VW + 7) / 8) * 8;

  localparam logic [IDXW-1:0] RegVtxA = IDXW'(0);
  localparam logic [IDXW-1:0] RegVtxB = IDXW'(1);
  localparam logic [IDXW-1:0] RegVtxC = IDXW'(2);
  localparam logic [IDXW-1:0] RegMat  = IDXW'(3);
  localparam logic [IDXW-1:0] RegEps  = IDXW'(4);

  localparam logic [QTW-1:0] QPosMax = {1'b0, {(QTW-1){1'b1}}};
  localparam logic [QTW-1:0] QNegMag = {1'b1, {(QTW-1){1'b0}}};

  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][QW-1:0] nrm_t;

  typedef struct packed {
    logic hit;
    vec_t org;
    vec_t dir;
  } rti_side_t;

  typedef struct packed {
    rti_side_t            side;
    logic [DW-1:0]        dabs;
    logic [2:0][DW-1:0]   nabs;
    logic [2:0]           neg;
  } rti_fr_t;

  typedef struct packed {
    rti_side_t            side;
    logic [2:0][QTW-1:0]  quo;
    logic [2:0]           neg;
    logic [2:0]           ovf;
  } rti_dq_t;

  typedef struct packed {
    logic [MATW-1:0] mat;
    nrm_t            nrm;
    vec_t            pt;
    logic [QTW-1:0]  v;
    logic [QTW-1:0]  u;
    logic [QTW-1:0]  t;
  } rti_res_t;

  localparam int OTDW = (($bits(rti_res_t) + 7) / 8) * 8;

endpackage

FILE: hw/rtl/rti_front.sv
// front pipeline: edges, cross products, split dot products and hit test
module rti_front
  import rti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [VW-1:0]   org_i,
  input  logic [VW-1:0]   dir_i,
  input  logic [VW-1:0]   vtx_a_i,
  input  logic [VW-1:0]   vtx_b_i,
  input  logic [VW-1:0]   vtx_c_i,
  input  logic [EPSW-1:0] eps_i,
  output logic            valid_o,
  output rti_fr_t         fr_o
);

  logic signed [EW-1:0] e1_w [3];
  logic signed [EW-1:0] e2_w [3];
  logic signed [EW-1:0] s_w  [3];
  logic [5:0]           vld_q;

  vec_t                 org1_q, dir1_q, org2_q, dir2_q, org3_q, dir3_q;
  vec_t                 org4_q, dir4_q, org5_q, dir5_q;
  logic signed [EW-1:0] s1_q [3];
  logic signed [EW-1:0] s2_q [3];
  logic signed [EW-1:0] s3_q [3];
  logic signed [PW-1:0] pm_q [3][2];
  logic signed [QW-1:0] qm_q [3][2];
  logic signed [PW-1:0] p3_q [3];
  logic signed [QW-1:0] q3_q [3];
  logic signed [EW-1:0] opa_w [4][3];
  logic signed [QW-1:0] opb_w [4][3];
  logic signed [MW-1:0] ml_q [4][3];
  logic signed [MW-1:0] mh_q [4][3];
  logic signed [DW-1:0] dot_w [4];
  logic signed [DW-1:0] dot5_q [4];
  logic signed [DW:0]   uv_w, det_w;
  logic                 det_neg_w, in_w, par_w;
  logic [DW-1:0]        dabs_w;
  rti_fr_t              fr_d, fr_q;

  for (genvar k = 0; k < 3; k++) begin : g_edge
    assign e1_w[k] = EW'($signed(vtx_b_i[k*CW +: CW])) - EW'($signed(vtx_a_i[k*CW +: CW]));
    assign e2_w[k] = EW'($signed(vtx_c_i[k*CW +: CW])) - EW'($signed(vtx_a_i[k*CW +: CW]));
    assign s_w[k]  = EW'($signed(org_i[k*CW +: CW])) - EW'($signed(vtx_a_i[k*CW +: CW]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // stage 1: origin relative to first vertex
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      org1_q <= org_i;
      dir1_q <= dir_i;
      for (int k = 0; k < 3; k++) begin
        s1_q[k] <= s_w[k];
      end
    end
  end

  // stage 2: cross product terms of p = dir x e2 and q = s x e1
  for (genvar k = 0; k < 3; k++) begin : g_crs
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pm_q[k][0] <= PW'($signed(dir1_q[K1])) * PW'(e2_w[K2]);
        pm_q[k][1] <= PW'($signed(dir1_q[K2])) * PW'(e2_w[K1]);
        qm_q[k][0] <= QW'(s1_q[K1]) * QW'(e1_w[K2]);
        qm_q[k][1] <= QW'(s1_q[K2]) * QW'(e1_w[K1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      org2_q <= org1_q;
      dir2_q <= dir1_q;
      s2_q   <= s1_q;
    end
  end

  // stage 3: cross product differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        p3_q[k] <= pm_q[k][0] - pm_q[k][1];
        q3_q[k] <= qm_q[k][0] - qm_q[k][1];
      end
      org3_q <= org2_q;
      dir3_q <= dir2_q;
      s3_q   <= s2_q;
    end
  end

  // stage 4: dot product terms split in low and high halves
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa_w[0][k] = e1_w[k];
      opb_w[0][k] = QW'(p3_q[k]);
      opa_w[1][k] = s3_q[k];
      opb_w[1][k] = QW'(p3_q[k]);
      opa_w[2][k] = EW'($signed(dir3_q[k]));
      opb_w[2][k] = q3_q[k];
      opa_w[3][k] = e2_w[k];
      opb_w[3][k] = q3_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          ml_q[j][k] <= MW'(opa_w[j][k]) * MW'($signed({1'b0, opb_w[j][k][SPL-1:0]}));
          mh_q[j][k] <= MW'(opa_w[j][k]) * MW'($signed(opb_w[j][k][QW-1:SPL]));
        end
      end
      org4_q <= org3_q;
      dir4_q <= dir3_q;
    end
  end

  // stage 5: det, u, v and t numerator
  always_comb begin
    logic signed [DW-1:0] acc;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        acc = acc + (DW'(mh_q[j][k]) <<< SPL) + DW'(ml_q[j][k]);
      end
      dot_w[j] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot5_q <= dot_w;
      org5_q <= org4_q;
      dir5_q <= dir4_q;
    end
  end

  // stage 6: bounds test and magnitudes for the dividers
  always_comb begin
    det_neg_w = dot5_q[0][DW-1];
    det_w     = (DW+1)'(dot5_q[0]);
    uv_w      = (DW+1)'(dot5_q[1]) + (DW+1)'(dot5_q[2]);
    if (!det_neg_w) begin
      in_w = !(dot5_q[1] < 0 || dot5_q[1] > dot5_q[0] || dot5_q[2] < 0 || uv_w > det_w);
    end else begin
      in_w = !(dot5_q[1] > 0 || dot5_q[1] < dot5_q[0] || dot5_q[2] > 0 || uv_w < det_w);
    end
    dabs_w = det_neg_w ? DW'(-dot5_q[0]) : DW'(dot5_q[0]);
    par_w  = dabs_w <= DW'(eps_i);

    fr_d.side.hit = in_w && !par_w;
    fr_d.side.org = org5_q;
    fr_d.side.dir = dir5_q;
    fr_d.dabs     = dabs_w;
    fr_d.nabs[0]  = dot5_q[3][DW-1] ? DW'(-dot5_q[3]) : DW'(dot5_q[3]);
    fr_d.nabs[1]  = dot5_q[1][DW-1] ? DW'(-dot5_q[1]) : DW'(dot5_q[1]);
    fr_d.nabs[2]  = dot5_q[2][DW-1] ? DW'(-dot5_q[2]) : DW'(dot5_q[2]);
    fr_d.neg[0]   = dot5_q[3][DW-1] ^ det_neg_w;
    fr_d.neg[1]   = dot5_q[1][DW-1] ^ det_neg_w;
    fr_d.neg[2]   = dot5_q[2][DW-1] ^ det_neg_w;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr_q <= fr_d;
    end
  end

  assign valid_o = vld_q[5];
  assign fr_o    = fr_q;

endmodule

FILE: hw/rtl/rti_div.sv
// pipelined restoring divider for t, u and v; every stage after the first retires one quotient bit
module rti_div
  import rti_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  rti_fr_t fr_i,
  output logic    valid_o,
  output rti_dq_t dq_o
);

  localparam int NST = QTW + 1;

  typedef struct packed {
    rti_side_t           side;
    logic [DW-1:0]       d;
    logic [2:0][NW-1:0]  rem;
    logic [2:0][QTW-1:0] quo;
    logic [2:0]          neg;
    logic [2:0]          ovf;
  } div_st_t;

  div_st_t        st_q [NST];
  div_st_t        nx_w [NST];
  logic [NST-1:0] vld_q;

  always_comb begin
    logic [RW-1:0] dsh;
    nx_w[0].side = fr_i.side;
    nx_w[0].d    = fr_i.dabs;
    nx_w[0].neg  = fr_i.neg;
    nx_w[0].quo  = '0;
    for (int j = 0; j < 3; j++) begin
      nx_w[0].rem[j] = {fr_i.nabs[j], FXW'(0)};
      nx_w[0].ovf[j] = (DW+FXW)'(fr_i.nabs[j]) >= {fr_i.dabs, FXW'(0)};
    end
    for (int g = 1; g < NST; g++) begin
      nx_w[g] = st_q[g-1];
      dsh = RW'(st_q[g-1].d) << (QTW - g);
      for (int j = 0; j < 3; j++) begin
        if (RW'(st_q[g-1].rem[j]) >= dsh) begin
          nx_w[g].rem[j]          = st_q[g-1].rem[j] - dsh[NW-1:0];
          nx_w[g].quo[j][QTW - g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= nx_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  assign valid_o   = vld_q[NST-1];
  assign dq_o.side = st_q[NST-1].side;
  assign dq_o.quo  = st_q[NST-1].quo;
  assign dq_o.neg  = st_q[NST-1].neg;
  assign dq_o.ovf  = st_q[NST-1].ovf;

endmodule

FILE: hw/rtl/rti_back.sv
// back pipeline: quotient saturation, hit point and output register
module rti_back
  import rti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rti_dq_t         dq_i,
  input  nrm_t            nrm_i,
  input  logic [MATW-1:0] mat_i,
  output logic            valid_o,
  output logic            hit_o,
  output rti_res_t        res_o
);

  localparam int PRW = QTW + CW;
  localparam int SHW = PRW - FXW;
  localparam int SMW = SHW + 1;
  localparam logic signed [PRW-1:0] Rnd  = PRW'(1) <<< (FXW - 1);
  localparam logic signed [SMW-1:0] CMax = SMW'((1 << (CW - 1)) - 1);
  localparam logic signed [SMW-1:0] CMin = -CMax - SMW'(1);

  logic [QTW-1:0]        sat_w [3];
  logic [QTW-1:0]        tq1_q [3];
  logic [QTW-1:0]        tq2_q [3];
  rti_side_t             side1_q, side2_q;
  logic signed [PRW-1:0] prod_q [3];
  logic [1:0]            vld_q;
  logic signed [PRW-1:0] rnd_w;
  logic signed [SMW-1:0] sum_w;
  rti_res_t              res_d, res_q;
  logic                  hit_q, valid_q;

  // stage 1: saturate quotients to the signed 32-bit range
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!dq_i.neg[j]) begin
        sat_w[j] = (dq_i.ovf[j] || dq_i.quo[j][QTW-1]) ? QPosMax : dq_i.quo[j];
      end else begin
        sat_w[j] = (dq_i.ovf[j] || dq_i.quo[j] > QNegMag) ? QNegMag : -dq_i.quo[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tq1_q   <= sat_w;
      side1_q <= dq_i.side;
    end
  end

  // stage 2: t times direction
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= PRW'($signed(tq1_q[0])) * PRW'($signed(side1_q.dir[k]));
      end
      tq2_q   <= tq1_q;
      side2_q <= side1_q;
    end
  end

  // stage 3: round, add origin, clamp, zero on miss
  always_comb begin
    res_d = '0;
    for (int k = 0; k < 3; k++) begin
      rnd_w = (prod_q[k] + Rnd) >>> FXW;
      sum_w = SMW'($signed(side2_q.org[k])) + SMW'($signed(rnd_w[SHW-1:0]));
      if (sum_w > CMax) begin
        res_d.pt[k] = CW'(CMax);
      end else if (sum_w < CMin) begin
        res_d.pt[k] = CW'(CMin);
      end else begin
        res_d.pt[k] = CW'(sum_w);
      end
    end
    res_d.t   = tq2_q[0];
    res_d.u   = tq2_q[1];
    res_d.v   = tq2_q[2];
    res_d.nrm = nrm_i;
    res_d.mat = mat_i;
    if (!side2_q.hit) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[0], valid_i};
      valid_q <= vld_q[1];
      hit_q   <= side2_q.hit;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign res_o   = res_q;

endmodule

FILE: hw/rtl/ray_triangle_intersect.sv
// top level of the pipelined two-sided ray/triangle intersection tester
//
// Rays enter on the s_axis word channel, one ray per word, and every ray
// gives exactly one result word on m_axis, in order. m_axis_tuser carries
// the hit flag; on a miss all of m_axis_tdata is zero.
// Triangle vertices, material tag and determinant threshold are written on
// the cfg channel, which is always ready; write them only while no ray is
// in flight.
// From accept to result a ray passes six front stages (edges,
// cross products, split dot products, bounds test), 33 divider stages, each
// but the first retiring one quotient bit of t, u and v, and three back stages
// (saturation, t times direction, round and clamp into the output register).
// Throughput is one ray per cycle. When m_axis_tready is low with a result
// pending, the whole pipeline holds and s_axis_tready drops the same cycle;
// nothing is lost or repeated.
// Reset clears all configuration registers to zero and all pipeline valids.
module ray_triangle_intersect
  import rti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [ITDW-1:0] s_axis_tdata,  // ray_origin, ray_direction
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // hit_distance, bary_u, bary_v, point_x, point_y, point_z,
  // normal_x, normal_y, normal_z, hit_material
  output logic [OTDW-1:0] m_axis_tdata,
  output logic [0:0]      m_axis_tuser,  // hit_found
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IDXW-1:0] cfg_index_i,
  input  logic [VW-1:0]   cfg_data_i
);

  logic [VW-1:0]        vtx_a_q, vtx_b_q, vtx_c_q;
  logic [MATW-1:0]      mat_q;
  logic [EPSW-1:0]      eps_q;
  logic                 en;
  logic                 fr_vld, dq_vld, hit_w;
  rti_fr_t              fr_w;
  rti_dq_t              dq_w;
  rti_res_t             res_w;
  logic signed [EW-1:0] n1_w [3];
  logic signed [EW-1:0] n2_w [3];
  nrm_t                 nrm_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_a_q <= '0;
      vtx_b_q <= '0;
      vtx_c_q <= '0;
      mat_q   <= '0;
      eps_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegVtxA: vtx_a_q <= cfg_data_i;
        RegVtxB: vtx_b_q <= cfg_data_i;
        RegVtxC: vtx_c_q <= cfg_data_i;
        RegMat:  mat_q   <= cfg_data_i[MATW-1:0];
        RegEps:  eps_q   <= cfg_data_i[EPSW-1:0];
        default: ;
      endcase
    end
  end

  // triangle normal follows the vertex registers
  for (genvar k = 0; k < 3; k++) begin : g_nrm
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    assign n1_w[k] = EW'($signed(vtx_b_q[k*CW +: CW])) - EW'($signed(vtx_a_q[k*CW +: CW]));
    assign n2_w[k] = EW'($signed(vtx_c_q[k*CW +: CW])) - EW'($signed(vtx_a_q[k*CW +: CW]));
    always_ff @(posedge clk_i) begin
      nrm_q[k] <= QW'(n1_w[K1]) * QW'(n2_w[K2]) - QW'(n1_w[K2]) * QW'(n2_w[K1]);
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rti_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .org_i   (s_axis_tdata[VW-1:0]),
    .dir_i   (s_axis_tdata[2*VW-1:VW]),
    .vtx_a_i (vtx_a_q),
    .vtx_b_i (vtx_b_q),
    .vtx_c_i (vtx_c_q),
    .eps_i   (eps_q),
    .valid_o (fr_vld),
    .fr_o    (fr_w)
  );

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .fr_i    (fr_w),
    .valid_o (dq_vld),
    .dq_o    (dq_w)
  );

  rti_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dq_vld),
    .dq_i    (dq_w),
    .nrm_i   (nrm_q),
    .mat_i   (mat_q),
    .valid_o (m_axis_tvalid),
    .hit_o   (hit_w),
    .res_o   (res_w)
  );

  assign m_axis_tdata = {(OTDW - $bits(rti_res_t))'(0), res_w};
  assign m_axis_tuser = hit_w;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss word carries nonzero data");

  a_hit_mat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> res_w.mat == mat_q)
    else $error("hit word material differs from register");

  a_bary_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !res_w.u[QTW-1] && !res_w.v[QTW-1])
    else $error("barycentric coordinate negative on hit");

endmodule
